// ===== rtl/bf3_pkg.sv =====
// Shared constants, types and tables of the 3x3 box filter.
package bf3_pkg;

  localparam int MAX_FRAME   = 1024;
  localparam int COL_W       = $clog2(MAX_FRAME);
  localparam int ROW_W       = $clog2(MAX_FRAME + 1);
  localparam int SIZE_W      = 11;
  localparam int FRAME_RESET = 1024;
  localparam int CH_W        = 16;
  localparam int PIX_W       = 3 * CH_W;
  localparam int POS_W       = 10;
  localparam int SUM_W       = 20;
  localparam int CNT_W       = 4;
  localparam int RECIP_SH    = 20;
  localparam int RECIP_W     = 21;
  localparam int QDEPTH      = 4;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int NBANKS      = 3;
  localparam int BANK_W      = 2;

  typedef logic [BANK_W-1:0] bank_t;

  typedef enum logic [1:0] {
    FS_TAKE,
    FS_CLIP,
    FS_PRE
  } front_state_t;

  // What the back end needs to build one output word
  typedef struct packed {
    logic             emit;
    logic [COL_W-1:0] orow;
    logic [COL_W-1:0] ocol;
    logic             top_ok;
    logic             bot_ok;
    logic             left_ok;
    logic             right_ok;
    logic             last;
    logic             done;
  } emit_t;

  // One back-end operation: optional line store write, one column load
  typedef struct packed {
    logic             wr;
    bank_t            wbank;
    logic [COL_W-1:0] col;
    logic [PIX_W-1:0] pix;
    bank_t            b1;
    bank_t            b2;
    emit_t            e;
  } op_t;

  function automatic bank_t bank_inc(input bank_t b);
    bank_t r;
    r = (b == bank_t'(NBANKS - 1)) ? bank_t'(0) : bank_t'(b + bank_t'(1));
    return r;
  endfunction

  // floor(2^RECIP_SH / d) for neighbourhood sizes 1..9
  function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] d);
    logic [RECIP_W-1:0] r;
    case (d)
      4'd1:    r = 21'd1048576;
      4'd2:    r = 21'd524288;
      4'd3:    r = 21'd349525;
      4'd4:    r = 21'd262144;
      4'd5:    r = 21'd209715;
      4'd6:    r = 21'd174762;
      4'd7:    r = 21'd149796;
      4'd8:    r = 21'd131072;
      4'd9:    r = 21'd116508;
      default: r = 21'd1048576;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/bf3_ifs.sv =====
// Valid/ready channel interfaces for pixel words and result words.
interface bf3_pix_if import bf3_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            req_type;
  logic [CH_W-1:0] in_red;
  logic [CH_W-1:0] in_green;
  logic [CH_W-1:0] in_blue;

  modport source (output valid, req_type, in_red, in_green, in_blue, input ready);
  modport sink   (input valid, req_type, in_red, in_green, in_blue, output ready);
endinterface

interface bf3_res_if import bf3_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CH_W-1:0]  out_red;
  logic [CH_W-1:0]  out_green;
  logic [CH_W-1:0]  out_blue;
  logic [POS_W-1:0] out_row;
  logic [POS_W-1:0] out_col;
  logic             last_of_run;
  logic             frame_done;

  modport source (output valid, out_red, out_green, out_blue, out_row, out_col,
                  last_of_run, frame_done, input ready);
  modport sink   (input valid, out_red, out_green, out_blue, out_row, out_col,
                  last_of_run, frame_done, output ready);
endinterface

// ===== rtl/bf3_queue.sv =====
// Short operation queue between front and back end.
module bf3_queue import bf3_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  op_t  push_op,
  output logic full,
  input  logic pop,
  output logic avail,
  output op_t  head
);

  op_t               slots [QDEPTH];
  logic [QPTR_W-1:0] wp;
  logic [QPTR_W-1:0] rp;
  logic [QPTR_W:0]   fill;

  assign head  = slots[rp];
  assign avail = (fill != '0);
  assign full  = (fill == (QPTR_W+1)'(QDEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wp] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= '0;
      rp   <= '0;
      fill <= '0;
    end else begin
      if (push) wp <= wp + QPTR_W'(1);
      if (pop)  rp <= rp + QPTR_W'(1);
      case ({push, pop})
        2'b10:   fill <= fill + (QPTR_W+1)'(1);
        2'b01:   fill <= fill - (QPTR_W+1)'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ===== rtl/bf3_front.sv =====
// Front end: frame counters, word classification and operation issue.
module bf3_front import bf3_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [SIZE_W-1:0] cfg_wr_data,
  bf3_pix_if.sink           pix,
  input  logic              q_full,
  output logic              push,
  output op_t               push_op
);

  function automatic logic [ROW_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
    logic [ROW_W-1:0] r;
    if (v == '0) r = ROW_W'(1);
    else if (int'(v) > MAX_FRAME) r = ROW_W'(MAX_FRAME);
    else r = ROW_W'(v);
    return r;
  endfunction

  front_state_t     state, state_next;
  logic [ROW_W-1:0] n_reg;
  logic [ROW_W-1:0] in_row;
  logic [COL_W-1:0] in_col;
  logic [COL_W-1:0] drain_col;
  logic [COL_W-1:0] pend_row;
  bank_t            wb, b1, b2;

  logic take, frame_in, last_col, last_drain, row_ge1, row_ge2;
  logic pix_take, drn_take;
  logic [ROW_W-1:0] n_m1;

  assign pix.ready  = (state == FS_TAKE) && !q_full;
  assign take       = pix.valid && pix.ready;
  assign n_m1       = n_reg - ROW_W'(1);
  assign frame_in   = (in_row == n_reg);
  assign last_col   = (ROW_W'(in_col) == n_m1);
  assign last_drain = (ROW_W'(drain_col) == n_m1);
  assign row_ge1    = (in_row != '0);
  assign row_ge2    = (in_row > ROW_W'(1));
  assign pix_take   = take && !pix.req_type && !frame_in;
  assign drn_take   = take && pix.req_type && frame_in;

  always_comb begin
    state_next = state;
    case (state)
      FS_TAKE: begin
        if (pix_take && last_col) begin
          if (row_ge1) state_next = FS_CLIP;
          else if (in_row + ROW_W'(1) == n_reg) state_next = FS_PRE;
        end
      end
      FS_CLIP: begin
        if (!q_full) state_next = frame_in ? FS_PRE : FS_TAKE;
      end
      FS_PRE: begin
        if (!q_full) state_next = FS_TAKE;
      end
      default: state_next = FS_TAKE;
    endcase
  end

  always_comb begin
    push    = 1'b0;
    push_op = '0;
    push_op.b1 = b1;
    push_op.b2 = b2;
    case (state)
      FS_TAKE: begin
        if (pix_take) begin
          push             = 1'b1;
          push_op.wr       = 1'b1;
          push_op.wbank    = wb;
          push_op.col      = in_col;
          push_op.pix      = {pix.in_red, pix.in_green, pix.in_blue};
          push_op.e.emit   = row_ge1 && (in_col != '0);
          push_op.e.orow   = COL_W'(in_row - ROW_W'(1));
          push_op.e.ocol   = in_col - COL_W'(1);
          push_op.e.top_ok = row_ge2;
          push_op.e.bot_ok = 1'b1;
          push_op.e.left_ok  = (in_col > COL_W'(1));
          push_op.e.right_ok = 1'b1;
          push_op.e.last   = !last_col;
        end else if (drn_take) begin
          push             = 1'b1;
          push_op.col      = drain_col + COL_W'(1);
          push_op.e.emit   = 1'b1;
          push_op.e.orow   = COL_W'(n_m1);
          push_op.e.ocol   = drain_col;
          push_op.e.top_ok = (n_reg > ROW_W'(1));
          push_op.e.left_ok  = (drain_col != '0);
          push_op.e.right_ok = !last_drain;
          push_op.e.last   = 1'b1;
          push_op.e.done   = last_drain;
        end
      end
      FS_CLIP: begin
        push             = !q_full;
        push_op.e.emit   = 1'b1;
        push_op.e.orow   = pend_row;
        push_op.e.ocol   = COL_W'(n_m1);
        push_op.e.top_ok = (pend_row != '0);
        push_op.e.bot_ok = 1'b1;
        push_op.e.left_ok = (n_reg > ROW_W'(1));
        push_op.e.last   = 1'b1;
      end
      FS_PRE: begin
        push = !q_full;
      end
      default: push = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= FS_TAKE;
      n_reg     <= clamp_size(SIZE_W'(FRAME_RESET));
      in_row    <= '0;
      in_col    <= '0;
      drain_col <= '0;
      pend_row  <= '0;
      wb        <= bank_t'(0);
      b1        <= bank_t'(2);
      b2        <= bank_t'(1);
    end else if (cfg_wr_en) begin
      state     <= FS_TAKE;
      n_reg     <= clamp_size(cfg_wr_data);
      in_row    <= '0;
      in_col    <= '0;
      drain_col <= '0;
      wb        <= bank_t'(0);
      b1        <= bank_t'(2);
      b2        <= bank_t'(1);
    end else begin
      state <= state_next;
      if (pix_take) begin
        if (last_col) begin
          in_col   <= '0;
          in_row   <= in_row + ROW_W'(1);
          pend_row <= COL_W'(in_row - ROW_W'(1));
          wb       <= bank_inc(wb);
          b1       <= bank_inc(b1);
          b2       <= bank_inc(b2);
        end else begin
          in_col <= in_col + COL_W'(1);
        end
      end else if (drn_take) begin
        if (last_drain) begin
          in_row    <= '0;
          in_col    <= '0;
          drain_col <= '0;
          wb        <= bank_t'(0);
          b1        <= bank_t'(2);
          b2        <= bank_t'(1);
        end else begin
          drain_col <= drain_col + COL_W'(1);
        end
      end
    end
  end

endmodule

// ===== rtl/bf3_back.sv =====
// Back end: line store banks, 3x3 window, sums and mean division.
module bf3_back import bf3_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_avail,
  input  op_t        q_op,
  output logic       pop,
  bf3_res_if.source  res
);

  logic adv;
  logic [PIX_W-1:0] rd [NBANKS];

  logic  s1_valid;
  op_t   s1_op;
  logic [PIX_W-1:0] win [3][3];
  logic  s2_valid;
  emit_t s2_e;
  logic  s3_valid;
  emit_t s3_e;
  logic [SUM_W-1:0] s3_sum [3];
  logic [CNT_W-1:0] s3_cnt;
  logic  s4_valid;
  emit_t s4_e;
  logic [SUM_W-1:0] s4_sum [3];
  logic [CH_W-1:0]  s4_q0  [3];
  logic [CNT_W-1:0] s4_cnt;

  logic [SUM_W-1:0] acc [3];
  logic [2:0] rmask, cmask;
  logic [1:0] nrows, ncols;
  logic [CH_W-1:0]  qfin [3];

  assign adv = !res.valid || res.ready;
  assign pop = adv && q_avail;

  for (genvar k = 0; k < NBANKS; k++) begin : g_bank
    logic [PIX_W-1:0] mem [MAX_FRAME];
    always_ff @(posedge clk) begin
      if (pop && q_op.wr && (q_op.wbank == bank_t'(k))) mem[q_op.col] <= q_op.pix;
      if (pop) rd[k] <= mem[q_op.col];
    end
  end

  // Masks: index 0 is top row / left column
  assign rmask = {s2_e.bot_ok, 1'b1, s2_e.top_ok};
  assign cmask = {s2_e.right_ok, 1'b1, s2_e.left_ok};
  assign nrows = 2'(1) + 2'(s2_e.top_ok) + 2'(s2_e.bot_ok);
  assign ncols = 2'(1) + 2'(s2_e.left_ok) + 2'(s2_e.right_ok);

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      acc[k] = '0;
      for (int c = 0; c < 3; c++) begin
        for (int r = 0; r < 3; r++) begin
          if (cmask[c] && rmask[r]) acc[k] = acc[k] + SUM_W'(win[c][r][k*CH_W +: CH_W]);
        end
      end
    end
  end

  // Reciprocal estimate is low by at most one: fix with a remainder check
  always_comb begin
    logic [SUM_W-1:0] rem;
    for (int k = 0; k < 3; k++) begin
      rem = s4_sum[k] - SUM_W'(s4_q0[k]) * SUM_W'(s4_cnt);
      qfin[k] = (rem >= SUM_W'(s4_cnt)) ? s4_q0[k] + CH_W'(1) : s4_q0[k];
    end
  end

  always_ff @(posedge clk) begin
    logic [SUM_W+RECIP_W-1:0] prod;
    if (adv) begin
      s1_op <= q_op;
      if (s1_valid) begin
        win[0] <= win[1];
        win[1] <= win[2];
        win[2][0] <= rd[s1_op.b2];
        win[2][1] <= rd[s1_op.b1];
        win[2][2] <= s1_op.pix;
      end
      s2_e   <= s1_op.e;
      s3_e   <= s2_e;
      s3_sum <= acc;
      s3_cnt <= CNT_W'(nrows) * CNT_W'(ncols);
      s4_e   <= s3_e;
      s4_sum <= s3_sum;
      s4_cnt <= s3_cnt;
      for (int k = 0; k < 3; k++) begin
        prod = s3_sum[k] * recip(s3_cnt);
        s4_q0[k] <= prod[RECIP_SH +: CH_W];
      end
      res.out_blue    <= qfin[0];
      res.out_green   <= qfin[1];
      res.out_red     <= qfin[2];
      res.out_row     <= POS_W'(s4_e.orow);
      res.out_col     <= POS_W'(s4_e.ocol);
      res.last_of_run <= s4_e.last;
      res.frame_done  <= s4_e.done;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      res.valid <= 1'b0;
    end else if (adv) begin
      s1_valid  <= q_avail;
      s2_valid  <= s1_valid && s1_op.e.emit;
      s3_valid  <= s2_valid;
      s4_valid  <= s3_valid;
      res.valid <= s4_valid;
    end
  end

endmodule

// ===== rtl/box_filter_3x3_rgb.sv =====
// Top level of the streaming 3x3 RGB box filter.
//
// Use: write frame_size through cfg_wr_en/cfg_wr_data while idle; a write
// restarts the frame. Send the frame's pixels on pix in raster order with
// req_type low, then one drain word (req_type high) per column of the last
// row. Output row r-1 leaves on res while input row r arrives; the drain
// words release the last row. Each result word carries the clipped 3x3 mean
// per channel, its row and column, last_of_run on the final word caused by
// an input word and frame_done on the frame's last pixel.
// Throughput: one input word per cycle while the queue has room, except at
// the end of each row from the second on, where the second result stalls
// pix, and at frame completion for the drain column preload. The back end's
// output register paces result words: one per cycle while res is ready.
// Path from input word to result word: queue, line store read, window, sum,
// reciprocal multiply, remainder correction.
// Reset clears counters, queue and pipeline valids; line store contents are
// undefined until written and never enter a sum before that. When res stalls,
// the back end holds, the four-entry queue fills and pix.ready drops.
module box_filter_3x3_rgb import bf3_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [SIZE_W-1:0] cfg_wr_data,
  bf3_pix_if.sink           pix,
  bf3_res_if.source         res
);

  logic push, q_full, q_avail, pop;
  op_t  push_op, q_head;

  // Classify words and issue back-end operations
  bf3_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .pix         (pix),
    .q_full      (q_full),
    .push        (push),
    .push_op     (push_op)
  );

  // Decouple the two ends so each can stall on its own
  bf3_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_op (push_op),
    .full    (q_full),
    .pop     (pop),
    .avail   (q_avail),
    .head    (q_head)
  );

  // Store lines, build the window and produce the means
  bf3_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_avail (q_avail),
    .q_op    (q_head),
    .pop     (pop),
    .res     (res)
  );

endmodule

// ===== rtl/bf3_checker.sv =====
// Port-level checks on the result channel, bound to the top level.
module bf3_checker import bf3_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             valid,
  input logic             ready,
  input logic [CH_W-1:0]  out_red,
  input logic [POS_W-1:0] out_row,
  input logic [POS_W-1:0] out_col,
  input logic             last_of_run,
  input logic             frame_done
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    valid && !ready |=> valid && $stable(out_red) && $stable(out_row) && $stable(out_col))
    else $error("result word changed while stalled");

  a_rst: assert property (@(posedge clk) rst |=> !valid)
    else $error("result valid after reset");

  a_done_last: assert property (@(posedge clk) disable iff (rst)
    valid && frame_done |-> last_of_run)
    else $error("frame_done without last_of_run");

  a_done_diag: assert property (@(posedge clk) disable iff (rst)
    valid && frame_done |-> out_row == out_col)
    else $error("frame_done off the corner pixel");

endmodule

bind box_filter_3x3_rgb bf3_checker u_bf3_checker (
  .clk         (clk),
  .rst         (rst),
  .valid       (res.valid),
  .ready       (res.ready),
  .out_red     (res.out_red),
  .out_row     (res.out_row),
  .out_col     (res.out_col),
  .last_of_run (res.last_of_run),
  .frame_done  (res.frame_done)
);
